/* sv/malad_pkg.sv */
package malad_pkg;

  localparam int PADDR_W     = 4;
  localparam int DIV_STEPS   = 64;
  localparam int SQRT_STEPS  = 32;

  localparam logic [14:0] THRESHOLD_RESET = 15'd512;
  localparam logic [11:0] ALONG_RESET     = 12'd128;
  localparam logic [11:0] CROSS_RESET     = 12'd512;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ALONG     = 2'd1,
    REG_CROSS     = 2'd2,
    REG_NONE      = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [14:0] speed_threshold;
    logic [11:0] along_weight;
    logic [11:0] cross_weight;
  } cfg_t;

  // restoring divider step state: x shifts numerator bits out, quotient bits in
  typedef struct packed {
    logic        sat;
    logic        weighted;
    logic [39:0] d;
    logic [39:0] rem;
    logic [63:0] x;
  } div_t;

  typedef struct packed {
    logic        sat;
    logic        weighted;
    logic [63:0] x;
    logic [31:0] root;
    logic [33:0] rem;
  } sqrt_t;

endpackage

/* sv/malad_if.sv */
interface malad_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] meas_x;
  logic signed [31:0] meas_y;
  logic signed [31:0] pred_x;
  logic signed [31:0] pred_y;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;

  modport source (output valid, meas_x, meas_y, pred_x, pred_y, vel_x, vel_y, input ready);
  modport sink (input valid, meas_x, meas_y, pred_x, pred_y, vel_x, vel_y, output ready);
endinterface

interface malad_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] distance;
  logic        weighted_used;

  modport source (output valid, distance, weighted_used, input ready);
  modport sink (input valid, distance, weighted_used, output ready);
endinterface

/* sv/motion_aligned_location_distance.sv */
// Motion-aligned location distance: one measured/predicted position pair and the
// track velocity go in per transfer, one distance comes out per transfer, in order.
// A new item is taken every clock unless stalled; the pipeline has 10 arithmetic
// stages, a 64-stage restoring divider at one quotient bit per stage, a 32-stage
// square root at one root bit per stage, and the output register. It stalls as a
// whole on output back-pressure; its first stage still takes a transfer while empty.
// The user must write APB registers 0x0 (threshold), 0x4 (along weight) and 0x8
// (cross weight) only while no item is in flight; the block does not enforce this.
module motion_aligned_location_distance (
  input  logic                          clk,
  input  logic                          rst,
  malad_in_if.sink                      item,
  malad_out_if.source                   result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [malad_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import malad_pkg::*;

  cfg_t  cfg;
  logic  adv;         // whole pipeline moves
  logic  en_first;    // first stage may also fill a bubble
  logic  first_full;  // first stage holds an item

  logic  div_valid [0:DIV_STEPS];
  div_t  div_data  [0:DIV_STEPS];
  logic  sq_valid  [0:SQRT_STEPS];
  sqrt_t sq_data   [0:SQRT_STEPS];

  logic        round_up;
  logic [31:0] root, dist_next;

  assign adv        = !result.valid || result.ready;
  assign item.ready = en_first;

  malad_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  malad_front u_front (
    .clk, .rst,
    .en_first   (en_first),
    .en         (adv),
    .in_valid   (item.valid),
    .meas_x     (item.meas_x),
    .meas_y     (item.meas_y),
    .pred_x     (item.pred_x),
    .pred_y     (item.pred_y),
    .vel_x      (item.vel_x),
    .vel_y      (item.vel_y),
    .cfg        (cfg),
    .first_full (first_full),
    .out_valid  (div_valid[0]),
    .out_data   (div_data[0])
  );

  // first stage empty: it can load even while the rest is held
  assign en_first = adv || !first_full;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    malad_div_step u_step (
      .clk, .rst, .en(adv),
      .in_valid(div_valid[i]), .in_data(div_data[i]),
      .out_valid(div_valid[i+1]), .out_data(div_data[i+1])
    );
  end

  // quotient feeds the root extraction
  assign sq_valid[0]         = div_valid[DIV_STEPS];
  assign sq_data[0].sat      = div_data[DIV_STEPS].sat;
  assign sq_data[0].weighted = div_data[DIV_STEPS].weighted;
  assign sq_data[0].x        = div_data[DIV_STEPS].x;
  assign sq_data[0].root     = '0;
  assign sq_data[0].rem      = '0;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    malad_sqrt_step u_step (
      .clk, .rst, .en(adv),
      .in_valid(sq_valid[j]), .in_data(sq_data[j]),
      .out_valid(sq_valid[j+1]), .out_data(sq_data[j+1])
    );
  end

  // round to nearest: remainder above the root means the upper neighbour is closer
  assign root     = sq_data[SQRT_STEPS].root;
  assign round_up = sq_data[SQRT_STEPS].rem > {2'd0, root};
  assign dist_next = (sq_data[SQRT_STEPS].sat || (round_up && (&root)))
                     ? 32'hFFFF_FFFF : root + {31'd0, round_up};

  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (adv) result.valid <= sq_valid[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.distance      <= dist_next;
      result.weighted_used <= sq_data[SQRT_STEPS].weighted;
    end
  end

endmodule

/* sv/malad_cfg.sv */
module malad_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [malad_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output malad_pkg::cfg_t               cfg
);
  import malad_pkg::*;

  reg_index_t idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_threshold <= THRESHOLD_RESET;
      cfg.along_weight    <= ALONG_RESET;
      cfg.cross_weight    <= CROSS_RESET;
    end else if (wr) begin
      case (idx)
        REG_THRESHOLD: cfg.speed_threshold <= pwdata[14:0];
        REG_ALONG:     cfg.along_weight    <= pwdata[11:0];
        REG_CROSS:     cfg.cross_weight    <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = {17'd0, cfg.speed_threshold};
      REG_ALONG:     prdata = {20'd0, cfg.along_weight};
      REG_CROSS:     prdata = {20'd0, cfg.cross_weight};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

/* sv/malad_front.sv */
module malad_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en_first,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] meas_x,
  input  logic signed [31:0] meas_y,
  input  logic signed [31:0] pred_x,
  input  logic signed [31:0] pred_y,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  malad_pkg::cfg_t    cfg,
  output logic               first_full,
  output logic               out_valid,
  output malad_pkg::div_t    out_data
);
  import malad_pkg::*;

  logic [9:1] v;

  // s1
  logic signed [32:0] dx1, dy1;
  logic signed [15:0] vx1, vy1;
  logic [31:0]        vxx1, vyy1;
  logic [29:0]        t2_1;
  // s2
  logic signed [32:0] dx2, dy2;
  logic signed [48:0] p1, p2, p3, p4;
  logic [31:0]        s2_2;
  logic               w2;
  // s3
  logic signed [49:0] a3, c3;
  logic [11:0]        wa3, wc3;
  logic [39:0]        d3;
  logic               w3;
  // s4
  logic [48:0]        ua4, uc4;
  logic [11:0]        wa4, wc4;
  logic [39:0]        d4;
  logic               w4;
  // s5
  logic [63:0]        all5, cll5;
  logic [48:0]        ahl5, chl5;
  logic [33:0]        ahh5, chh5;
  logic [11:0]        wa5, wc5;
  logic [39:0]        d5;
  logic               w5;
  // s6
  logic [97:0]        asq6, csq6;
  logic [11:0]        wa6, wc6;
  logic [39:0]        d6;
  logic               w6;
  // s7
  logic [60:0]        alo7, ahi7, clo7, chi7;
  logic [39:0]        d7;
  logic               w7;
  // s8
  logic [109:0]       at8, ct8;
  logic [39:0]        d8;
  logic               w8;
  // s9
  logic [109:0]       num9;
  logic [39:0]        d9;
  logic               w9;

  logic signed [49:0] a_sum, c_sum, a_neg, c_neg;
  logic signed [32:0] vx_e, vy_e;

  assign first_full = v[1];

  assign a_sum = $signed({p1[48], p1}) + $signed({p2[48], p2});
  assign c_sum = $signed({p3[48], p3}) - $signed({p4[48], p4});
  assign a_neg = -a3;
  assign c_neg = -c3;
  assign vx_e  = 33'(vx1);
  assign vy_e  = 33'(vy1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (en_first) v[1] <= in_valid;
      if (en) begin
        v[9:2]    <= v[8:1];
        out_valid <= v[9];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_first) begin
      dx1  <= $signed({meas_x[31], meas_x}) - $signed({pred_x[31], pred_x});
      dy1  <= $signed({meas_y[31], meas_y}) - $signed({pred_y[31], pred_y});
      vx1  <= vel_x;
      vy1  <= vel_y;
      vxx1 <= 32'($signed(vel_x) * $signed(vel_x));
      vyy1 <= 32'($signed(vel_y) * $signed(vel_y));
      t2_1 <= 30'(cfg.speed_threshold * cfg.speed_threshold);
    end
    if (en) begin
      // s2: speed test and projections onto the velocity
      dx2  <= dx1;
      dy2  <= dy1;
      s2_2 <= vxx1 + vyy1;
      w2   <= (vxx1 + vyy1) > {2'd0, t2_1};
      p1   <= 49'(vx_e * dx1);
      p2   <= 49'(vy_e * dy1);
      p3   <= 49'(vy_e * dx1);
      p4   <= 49'(vx_e * dy1);
      // s3: slow track falls back to plain offsets, unit weights, divisor 1
      w3   <= w2;
      a3   <= w2 ? a_sum : $signed({{17{dx2[32]}}, dx2});
      c3   <= w2 ? c_sum : $signed({{17{dy2[32]}}, dy2});
      wa3  <= w2 ? cfg.along_weight : 12'd1;
      wc3  <= w2 ? cfg.cross_weight : 12'd1;
      d3   <= w2 ? {s2_2, 8'd0} : 40'd1;
      // s4: magnitudes
      ua4  <= a3[49] ? a_neg[48:0] : a3[48:0];
      uc4  <= c3[49] ? c_neg[48:0] : c3[48:0];
      wa4  <= wa3;
      wc4  <= wc3;
      d4   <= d3;
      w4   <= w3;
      // s5: square partial products
      all5 <= 64'(ua4[31:0] * ua4[31:0]);
      ahl5 <= 49'(ua4[48:32] * ua4[31:0]);
      ahh5 <= 34'(ua4[48:32] * ua4[48:32]);
      cll5 <= 64'(uc4[31:0] * uc4[31:0]);
      chl5 <= 49'(uc4[48:32] * uc4[31:0]);
      chh5 <= 34'(uc4[48:32] * uc4[48:32]);
      wa5  <= wa4;
      wc5  <= wc4;
      d5   <= d4;
      w5   <= w4;
      // s6
      asq6 <= {ahh5, 64'd0} + {16'd0, ahl5, 33'd0} + {34'd0, all5};
      csq6 <= {chh5, 64'd0} + {16'd0, chl5, 33'd0} + {34'd0, cll5};
      wa6  <= wa5;
      wc6  <= wc5;
      d6   <= d5;
      w6   <= w5;
      // s7: weight partial products
      alo7 <= 61'(asq6[48:0] * wa6);
      ahi7 <= 61'(asq6[97:49] * wa6);
      clo7 <= 61'(csq6[48:0] * wc6);
      chi7 <= 61'(csq6[97:49] * wc6);
      d7   <= d6;
      w7   <= w6;
      // s8
      at8  <= {ahi7, 49'd0} + {49'd0, alo7};
      ct8  <= {chi7, 49'd0} + {49'd0, clo7};
      d8   <= d7;
      w8   <= w7;
      // s9
      num9 <= at8 + ct8;
      d9   <= d8;
      w9   <= w8;
      // s10: quotient of 2^64 or more saturates; else the high part is the first remainder
      out_data.sat      <= num9[109:64] >= {6'd0, d9};
      out_data.weighted <= w9;
      out_data.d        <= d9;
      out_data.rem      <= num9[103:64];
      out_data.x        <= num9[63:0];
    end
  end

endmodule

/* sv/malad_div_step.sv */
module malad_div_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  malad_pkg::div_t in_data,
  output logic            out_valid,
  output malad_pkg::div_t out_data
);
  import malad_pkg::*;

  logic [40:0] trial, diff;
  logic        take;

  assign trial = {in_data.rem, in_data.x[63]};
  assign diff  = trial - {1'b0, in_data.d};
  assign take  = trial >= {1'b0, in_data.d};

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.sat      <= in_data.sat;
      out_data.weighted <= in_data.weighted;
      out_data.d        <= in_data.d;
      out_data.rem      <= take ? diff[39:0] : trial[39:0];
      out_data.x        <= {in_data.x[62:0], take};
    end
  end

endmodule

/* sv/malad_sqrt_step.sv */
module malad_sqrt_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  malad_pkg::sqrt_t in_data,
  output logic             out_valid,
  output malad_pkg::sqrt_t out_data
);
  import malad_pkg::*;

  logic [35:0] acc, trial, diff;
  logic        take;

  assign acc   = {in_data.rem, in_data.x[63:62]};
  assign trial = {2'd0, in_data.root, 2'b01};
  assign diff  = acc - trial;
  assign take  = acc >= trial;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.sat      <= in_data.sat;
      out_data.weighted <= in_data.weighted;
      out_data.x        <= {in_data.x[61:0], 2'b00};
      out_data.root     <= {in_data.root[30:0], take};
      out_data.rem      <= take ? diff[33:0] : acc[33:0];
    end
  end

endmodule

/* sim/motion_aligned_location_distance_tb.sv */
module motion_aligned_location_distance_tb;
  import malad_pkg::*;

  // one position pair plus track velocity
  typedef struct {
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic signed [31:0] pred_x;
    logic signed [31:0] pred_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } pair_t;

  typedef struct {
    logic [31:0] distance;
    logic        weighted_used;
  } dist_t;

  // directed row: typed-in answer only where it is obvious
  typedef struct {
    pair_t       p;
    bit          typed;
    logic [31:0] distance;
    logic        weighted_used;
  } row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  malad_in_if  item_if ();
  malad_out_if res_if ();

  motion_aligned_location_distance dut (
    .clk     (clk),
    .rst     (rst),
    .item    (item_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block's registers, as the predictor sees them
  cfg_t  shadow_cfg;
  dist_t pending_dist[$];
  dist_t typed_dist[$];   // typed-in answers, in step with the directed rows
  bit    typed_flag[$];
  int    errors;
  int    n_in, n_out, n_weighted;
  int    quiet_cycles;
  bit    idle_on;         // random idling on both sides
  int    hold_req;        // receiver hold-off length, taken up once by the receiver
  int    hold_left;       // hold-off cycles still to run
  bit    hold_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact integer arithmetic at widths that cannot overflow.
  // ---------------------------------------------------------------------------
  function automatic dist_t motion_distance(pair_t p, cfg_t c);
    longint      ldx, ldy, lvx, lvy, a, cr;
    longint      s2, t2;
    logic [127:0] ua, uc, num, d2, div;
    logic [63:0] lo, r, t;
    dist_t       d;
    ldx = longint'(p.meas_x) - longint'(p.pred_x);
    ldy = longint'(p.meas_y) - longint'(p.pred_y);
    lvx = longint'(p.vel_x);
    lvy = longint'(p.vel_y);
    s2  = lvx * lvx + lvy * lvy;
    t2  = longint'(c.speed_threshold) * longint'(c.speed_threshold);
    d.weighted_used = (s2 > t2);
    if (d.weighted_used) begin
      // along and across parts, unnormalised by speed
      a   = lvx * ldx + lvy * ldy;
      cr  = lvy * ldx - lvx * ldy;
      ua  = {64'd0, (a < 0) ? -a : a};
      uc  = {64'd0, (cr < 0) ? -cr : cr};
      num = ua * {116'd0, c.along_weight} * ua + uc * {116'd0, c.cross_weight} * uc;
      div = {64'd0, s2} << 8;
      d2  = num / div;
    end else begin
      ua = {64'd0, (ldx < 0) ? -ldx : ldx};
      uc = {64'd0, (ldy < 0) ? -ldy : ldy};
      d2 = ua * ua + uc * uc;
    end
    if (d2[127:64] != 0) begin
      d.distance = 32'hFFFF_FFFF;
    end else begin
      lo = d2[63:0];
      r  = 0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= lo) r = t;
      end
      if (lo - r * r > r) r = r + 1;    // round to nearest
      d.distance = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    end
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: every accepted transfer files its expected distance.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && item_if.valid && item_if.ready) begin
      pair_t p;
      dist_t d;
      p.meas_x = item_if.meas_x;  p.meas_y = item_if.meas_y;
      p.pred_x = item_if.pred_x;  p.pred_y = item_if.pred_y;
      p.vel_x  = item_if.vel_x;   p.vel_y  = item_if.vel_y;
      d = motion_distance(p, shadow_cfg);
      if (typed_flag.size() > 0) begin
        // directed row: use the typed-in answer where one was given
        if (typed_flag.pop_front()) d = typed_dist.pop_front();
        else void'(typed_dist.pop_front());
      end
      pending_dist.insert(pending_dist.size(), d);
      n_in++;
    end
  end

  // Output side: compare with the oldest pending distance.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      dist_t d;
      n_out++;
      if (pending_dist.size() == 0) begin
        $error("result transfer with nothing pending: distance %h", res_if.distance);
        errors++;
      end else begin
        d = pending_dist.pop_front();
        if (res_if.distance !== d.distance) begin
          $error("distance: expected %h, actual %h", d.distance, res_if.distance);
          errors++;
        end
        if (res_if.weighted_used !== d.weighted_used) begin
          $error("weighted_used: expected %b, actual %b",
                 d.weighted_used, res_if.weighted_used);
          errors++;
        end
        if (d.weighted_used) n_weighted++;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req > 0 && !hold_seen) begin
      res_if.ready <= 1'b0;
      hold_left <= hold_req - 1;
      hold_seen <= 1'b1;
    end else begin
      res_if.ready <= !(idle_on && $urandom_range(99) < 17);
    end
  end

  // Watchdog: cycles with no transfer on any side.
  always @(posedge clk) begin
    if (rst || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)
        || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // APB write: setup then access; written on the access edge.
  task automatic reg_write(reg_index_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_THRESHOLD: shadow_cfg.speed_threshold = val[14:0];
      REG_ALONG:     shadow_cfg.along_weight    = val[11:0];
      REG_CROSS:     shadow_cfg.cross_weight    = val[11:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait for the pipe to drain, then idle on for margin
  task automatic drain();
    item_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_dist.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // offer one item; valid stays high across back-to-back transfers
  task automatic send_pair(pair_t p);
    while (idle_on && $urandom_range(99) < 17) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid  <= 1'b1;
    item_if.meas_x <= p.meas_x;
    item_if.meas_y <= p.meas_y;
    item_if.pred_x <= p.pred_x;
    item_if.pred_y <= p.pred_y;
    item_if.vel_x  <= p.vel_x;
    item_if.vel_y  <= p.vel_y;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
  endtask

  // random pair: mostly nearby offsets with speeds around the threshold,
  // some full-range noise so every bit toggles
  function automatic pair_t rand_pair(cfg_t c);
    pair_t p;
    int    kind;
    int    thr;
    kind = $urandom_range(9);
    thr  = c.speed_threshold;
    p.pred_x = $urandom;
    p.pred_y = $urandom;
    if (kind < 6) begin
      p.meas_x = p.pred_x + $signed($urandom_range(8191)) - 4096;
      p.meas_y = p.pred_y + $signed($urandom_range(8191)) - 4096;
      p.vel_x  = $signed($urandom_range(2 * thr + 64)) - thr - 32;
      p.vel_y  = $signed($urandom_range(2 * thr + 64)) - thr - 32;
      if (p.vel_x > 32767 || p.vel_x < -32768) p.vel_x = $urandom;
    end else if (kind < 8) begin
      p.meas_x = p.pred_x + ($signed($urandom) >>> $urandom_range(31));
      p.meas_y = p.pred_y + ($signed($urandom) >>> $urandom_range(31));
      p.vel_x  = $urandom;
      p.vel_y  = $urandom;
    end else begin
      p.meas_x = $urandom;
      p.meas_y = $urandom;
      p.vel_x  = $urandom;
      p.vel_y  = $urandom;
    end
    return p;
  endfunction

  function automatic row_t mk(int mx, int my, int px, int py, int vx, int vy,
                              bit typed, logic [31:0] d, logic w);
    row_t r;
    r.p.meas_x = mx;  r.p.meas_y = my;
    r.p.pred_x = px;  r.p.pred_y = py;
    r.p.vel_x  = vx;  r.p.vel_y  = vy;
    r.typed = typed;  r.distance = d;  r.weighted_used = w;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    row_t  rows[$];
    pair_t p;
    int    n_phase;
    int    n_rand;
    rst = 1'b1;
    psel = 1'b0;  penable = 1'b0;  pwrite = 1'b0;  paddr = '0;  pwdata = '0;
    item_if.valid = 1'b0;
    item_if.meas_x = '0;  item_if.meas_y = '0;
    item_if.pred_x = '0;  item_if.pred_y = '0;
    item_if.vel_x  = '0;  item_if.vel_y  = '0;
    shadow_cfg = '{THRESHOLD_RESET, ALONG_RESET, CROSS_RESET};
    idle_on = 1'b1;  hold_req = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset settings (threshold 2.0, weights 0.5 and 2.0)
    rows.insert(rows.size(), mk(0, 0, 0, 0, 0, 0, 1, 32'd0, 1'b0));      // all zero
    rows.insert(rows.size(), mk(256, 0, 0, 0, 0, 0, 1, 32'd256, 1'b0));  // one metre
    rows.insert(rows.size(), mk(0, -768, 0, 0, 0, 0, 1, 32'd768, 1'b0));
    rows.insert(rows.size(), mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h8000_0000, 0, 0, 1, 32'hFFFF_FFFF, 1'b0)); // saturates
    rows.insert(rows.size(), mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, -32768, -32768, 1, 32'hFFFF_FFFF, 1'b1));
    rows.insert(rows.size(), mk(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 32767, 32767,
                                1, 32'd0, 1'b1));                        // no offset
    // speed at threshold
    rows.insert(rows.size(), mk(256, 0, 0, 0, 512, 0, 1, 32'd256, 1'b0));
    rows.insert(rows.size(), mk(256, 0, 0, 0, 0, -512, 1, 32'd256, 1'b0));
    rows.insert(rows.size(), mk(256, 0, 0, 0, 513, 0, 0, '0, 1'b0));     // just above
    rows.insert(rows.size(), mk(256, 0, 0, 0, 0, 1024, 0, '0, 1'b0));    // pure cross
    rows.insert(rows.size(), mk(256, 256, 0, 0, 1024, 1024, 0, '0, 1'b0)); // pure along
    rows.insert(rows.size(), mk(-1000, 3000, 500, -200, -700, 900, 0, '0, 1'b0));
    rows.insert(rows.size(), mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32767, -32768,
                                0, '0, 1'b0));
    rows.insert(rows.size(), mk(1, 1, 0, 0, 32767, 1, 0, '0, 1'b0));
    // 512^2 < s2
    rows.insert(rows.size(), mk(-12345, 6789, 111, -222, 363, 363, 0, '0, 1'b0));
    foreach (rows[i]) begin
      typed_flag.insert(typed_flag.size(), rows[i].typed);
      typed_dist.insert(typed_dist.size(), '{rows[i].distance, rows[i].weighted_used});
    end
    foreach (rows[i]) send_pair(rows[i].p);
    drain();

    // phases: reset settings, threshold zero with full weights, zero weights with
    // the top threshold, a write with spare bits set, then random settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          reg_write(REG_THRESHOLD, 32'd0);
          reg_write(REG_ALONG, 32'd4095);
          reg_write(REG_CROSS, 32'd4095);
        end
        2: begin
          reg_write(REG_THRESHOLD, 32'd32767);
          reg_write(REG_ALONG, 32'd0);
          reg_write(REG_CROSS, 32'd0);
        end
        3: begin
          reg_write(REG_THRESHOLD, 32'hFFFF_8100);   // bits above width ignored
          reg_write(REG_ALONG, 32'hFFFF_F000);
          reg_write(REG_CROSS, 32'h0000_1100);
          reg_write(REG_NONE, 32'hFFFF_FFFF);        // unmapped, no effect
        end
        4, 5: begin
          reg_write(REG_THRESHOLD, $urandom_range(2000));
          reg_write(REG_ALONG, $urandom_range(4095));
          reg_write(REG_CROSS, $urandom_range(4095));
        end
        default: ;
      endcase
      n_phase = (ph == 2) ? 80 : 130;
      for (n_rand = 0; n_rand < n_phase; n_rand++) begin
        idle_on = !(ph == 4 && n_rand >= 20 && n_rand < 110);   // steady stretch
        if (ph == 1 && n_rand == 40) hold_req = 400;            // fill and stall
        if (ph == 5 && n_rand == 60) begin
          // sender waits for every pending result
          item_if.valid <= 1'b0;
          @(posedge clk);
          while (pending_dist.size() != 0) @(posedge clk);
        end
        p = rand_pair(shadow_cfg);
        send_pair(p);
      end
      drain();
    end

    $display("%0d pairs in, %0d distances out, %0d motion-weighted, over six settings",
             n_in, n_out, n_weighted);
    if (errors == 0 && pending_dist.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
